@@ rtl/core/wmr_pkg.sv @@
// Shared types, constants and divider step functions for the WENO half-point core.
package wmr_pkg;

   localparam int DIV_STEPS = 25;
   localparam int NUM_STAGES = 60;
   localparam int STG_DIV1 = 4;
   localparam int STG_SQ = STG_DIV1 + DIV_STEPS;
   localparam int STG_SUM = STG_SQ + 1;
   localparam int STG_DIV2 = STG_SUM + 1;
   localparam int STG_WGT = STG_DIV2 + DIV_STEPS;
   localparam int STG_MUL = STG_WGT + 1;
   localparam int STG_ACC = STG_MUL + 1;
   localparam int STG_OUT = STG_ACC + 1;

   localparam logic [63:0] EPS_TERM = 64'd201;
   localparam logic [24:0] ONE_Q24 = 25'h100_0000;
   localparam logic signed [61:0] ROUND_TERM = 62'sh100_0000;
   localparam logic [31:0] SAT_MAX = 32'h7fff_ffff;
   localparam logic [31:0] SAT_MIN = 32'h8000_0000;

   typedef struct packed {
      logic signed [31:0] um1;
      logic signed [31:0] u0;
      logic signed [31:0] up1;
      logic signed [31:0] up2;
   } smp_type;

   typedef struct packed {
      logic [63:0] rem;
      logic        bit_q;
   } wdiv_type;

   typedef struct packed {
      logic [26:0] rem;
      logic        bit_q;
   } ndiv_type;

   function automatic logic signed [35:0] sx36(input logic signed [31:0] s);
      return {{4{s[31]}}, s};
   endfunction

   function automatic logic [30:0] mag4(input logic signed [35:0] x);
      logic [35:0] m;
      m = x[35] ? 36'(-x) : 36'(x);
      return m[34:4];
   endfunction

   function automatic wdiv_type wide_step(input logic [63:0] rem, input logic [63:0] den,
                                          input logic first);
      logic [64:0] sh;
      wdiv_type r;
      sh = first ? {1'b0, rem} : {rem, 1'b0};
      if (sh >= {1'b0, den}) begin
         r.rem = 64'(sh - {1'b0, den});
         r.bit_q = 1'b1;
      end else begin
         r.rem = sh[63:0];
         r.bit_q = 1'b0;
      end
      return r;
   endfunction

   function automatic ndiv_type narrow_step(input logic [26:0] rem, input logic [26:0] den,
                                            input logic first);
      logic [27:0] sh;
      ndiv_type r;
      sh = first ? {1'b0, rem} : {rem, 1'b0};
      if (sh >= {1'b0, den}) begin
         r.rem = 27'(sh - {1'b0, den});
         r.bit_q = 1'b1;
      end else begin
         r.rem = sh[26:0];
         r.bit_q = 1'b0;
      end
      return r;
   endfunction

endpackage

@@ rtl/core/weno_midpoint_reconstruction_core.sv @@
// Top level of the pipelined five-point WENO half-point reconstruction core.
//
// The request channel carries one stencil item of five signed Q16.16 samples
// (i-2 to i+2); the response channel returns the saturated Q16.16 value at
// i+1/2. An item is taken when valid is high and stall is low.
// One item may enter every cycle while the request side is not stalled. The
// pipeline depth is set mainly by the two restoring dividers, each retiring
// one quotient bit per stage over 25 stages.
// The whole pipeline advances together; when the receiver stalls a waiting
// result, every stage holds and the request side is stalled in the same cycle,
// so nothing is lost or repeated. Synchronous reset clears all valid bits; the
// block accepts items in the first cycle after reset is released.
module weno_midpoint_reconstruction_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic signed [31:0] req_sample_m2,
   input  logic signed [31:0] req_sample_m1,
   input  logic signed [31:0] req_sample_center,
   input  logic signed [31:0] req_sample_p1,
   input  logic signed [31:0] req_sample_p2,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic signed [31:0] rsp_half_value
);
   import wmr_pkg::*;

   logic                 adv;
   logic [NUM_STAGES-1:0] vld_ff, vld_in;
   smp_type              smp_ff [STG_MUL];
   logic [30:0]          p_ff [3], p_in [3], q_ff [3], q_in [3];
   logic [61:0]          pp_ff [3], pp_in [3], qq_ff [3], qq_in [3];
   logic [63:0]          s_ff [3], s_in [3], sd_ff [3];
   logic [63:0]          m_ff, m_in;
   logic [63:0]          r1rem_ff [DIV_STEPS][3], r1rem_in [DIV_STEPS][3];
   logic [63:0]          den1_ff [DIV_STEPS][3], den1_in [DIV_STEPS][3];
   logic [24:0]          r1quo_ff [DIV_STEPS][3], r1quo_in [DIV_STEPS][3];
   logic [24:0]          a0_ff, a0_in, a2_ff, a2_in;
   logic [26:0]          a1_ff, a1_in;
   logic [26:0]          sum_ff, sum_in;
   logic [24:0]          n0_ff, n2_ff;
   logic [26:0]          rem2_ff [DIV_STEPS][2], rem2_in [DIV_STEPS][2];
   logic [26:0]          den2_ff [DIV_STEPS], den2_in [DIV_STEPS];
   logic [24:0]          quo2_ff [DIV_STEPS][2], quo2_in [DIV_STEPS][2];
   logic [24:0]          w0_ff, w0_in, w2_ff, w2_in;
   logic [26:0]          c1_ff, c1_in, c2_ff, c2_in;
   logic signed [59:0]   pr_ff [4], pr_in [4];
   logic signed [61:0]   acc_ff, acc_in;
   logic signed [31:0]   half_ff, half_in;

   assign adv = !(vld_ff[STG_OUT] && rsp_stall);
   assign req_stall = !adv;
   assign vld_in = {vld_ff[NUM_STAGES-2:0], req_valid};
   assign rsp_valid = vld_ff[STG_OUT];
   assign rsp_half_value = half_ff;

   function automatic logic signed [61:0] pr_in_ff_sum(input logic signed [59:0] a,
                                                       input logic signed [59:0] b,
                                                       input logic signed [59:0] c,
                                                       input logic signed [59:0] d);
      return -62'(a) + 62'(b) + 62'(c) - 62'(d);
   endfunction

   always_comb begin
      logic signed [35:0] xm2, xm1, xc, xp1, xp2;
      logic signed [35:0] pd [3];
      logic signed [35:0] qd [3];
      logic [49:0] sq [3];
      logic [24:0] w1;
      wdiv_type wst;
      ndiv_type nst;
      xm2 = sx36(req_sample_m2);
      xm1 = sx36(req_sample_m1);
      xc  = sx36(req_sample_center);
      xp1 = sx36(req_sample_p1);
      xp2 = sx36(req_sample_p2);
      pd[0] = xm2 - (xm1 <<< 2) + (xc <<< 1) + xc;
      qd[0] = xm2 - (xm1 <<< 1) + xc;
      pd[1] = xp1 - xm1;
      qd[1] = xm1 - (xc <<< 1) + xp1;
      pd[2] = (xc <<< 1) + xc - (xp1 <<< 2) + xp2;
      qd[2] = xc - (xp1 <<< 1) + xp2;
      for (int k = 0; k < 3; k++) begin
         p_in[k] = mag4(pd[k]);
         q_in[k] = mag4(qd[k]);
         pp_in[k] = p_ff[k] * p_ff[k];
         qq_in[k] = q_ff[k] * q_ff[k];
         s_in[k] = ({2'b00, pp_ff[k]} << 1) + {2'b00, pp_ff[k]} + ({2'b00, qq_ff[k]} << 3)
                 + ({2'b00, qq_ff[k]} << 2) + {2'b00, qq_ff[k]} + EPS_TERM;
      end
      m_in = s_ff[0];
      if (s_ff[1] < m_in) m_in = s_ff[1];
      if (s_ff[2] < m_in) m_in = s_ff[2];

      for (int k = 0; k < 3; k++) begin
         wst = wide_step(m_ff, sd_ff[k], 1'b1);
         r1rem_in[0][k] = wst.rem;
         r1quo_in[0][k] = {24'd0, wst.bit_q};
         den1_in[0][k] = sd_ff[k];
         for (int j = 1; j < DIV_STEPS; j++) begin
            wst = wide_step(r1rem_ff[j-1][k], den1_ff[j-1][k], 1'b0);
            r1rem_in[j][k] = wst.rem;
            r1quo_in[j][k] = {r1quo_ff[j-1][k][23:0], wst.bit_q};
            den1_in[j][k] = den1_ff[j-1][k];
         end
         sq[k] = r1quo_ff[DIV_STEPS-1][k] * r1quo_ff[DIV_STEPS-1][k];
      end
      a0_in = sq[0][48:24];
      a1_in = sq[1][48:22];
      a2_in = sq[2][48:24];
      sum_in = {2'b00, a0_ff} + a1_ff + {2'b00, a2_ff};

      nst = narrow_step({2'b00, n0_ff}, sum_ff, 1'b1);
      rem2_in[0][0] = nst.rem;
      quo2_in[0][0] = {24'd0, nst.bit_q};
      nst = narrow_step({2'b00, n2_ff}, sum_ff, 1'b1);
      rem2_in[0][1] = nst.rem;
      quo2_in[0][1] = {24'd0, nst.bit_q};
      den2_in[0] = sum_ff;
      for (int j = 1; j < DIV_STEPS; j++) begin
         for (int k = 0; k < 2; k++) begin
            nst = narrow_step(rem2_ff[j-1][k], den2_ff[j-1], 1'b0);
            rem2_in[j][k] = nst.rem;
            quo2_in[j][k] = {quo2_ff[j-1][k][23:0], nst.bit_q};
         end
         den2_in[j] = den2_ff[j-1];
      end

      w0_in = quo2_ff[DIV_STEPS-1][0];
      w2_in = quo2_ff[DIV_STEPS-1][1];
      w1 = ONE_Q24 - w0_in - w2_in;
      c1_in = ({2'b00, w0_in} << 1) + {2'b00, w0_in} + {2'b00, w1};
      c2_in = ({2'b00, w2_in} << 1) + {2'b00, w2_in} + {2'b00, w1};

      pr_in[0] = smp_ff[STG_WGT].um1 * $signed({3'b000, w0_ff});
      pr_in[1] = smp_ff[STG_WGT].u0 * $signed({1'b0, c1_ff});
      pr_in[2] = smp_ff[STG_WGT].up1 * $signed({1'b0, c2_ff});
      pr_in[3] = smp_ff[STG_WGT].up2 * $signed({3'b000, w2_ff});
      acc_in = 62'(pr_in_ff_sum(pr_ff[0], pr_ff[1], pr_ff[2], pr_ff[3])) + ROUND_TERM;

      if (&acc_ff[61:56] || ~|acc_ff[61:56]) begin
         half_in = acc_ff[56:25];
      end else begin
         half_in = acc_ff[61] ? SAT_MIN : SAT_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         smp_ff[0] <= {req_sample_m1, req_sample_center, req_sample_p1, req_sample_p2};
         for (int i = 1; i < STG_MUL; i++) begin
            smp_ff[i] <= smp_ff[i-1];
         end
         p_ff <= p_in;
         q_ff <= q_in;
         pp_ff <= pp_in;
         qq_ff <= qq_in;
         s_ff <= s_in;
         sd_ff <= s_ff;
         m_ff <= m_in;
         r1rem_ff <= r1rem_in;
         r1quo_ff <= r1quo_in;
         den1_ff <= den1_in;
         a0_ff <= a0_in;
         a1_ff <= a1_in;
         a2_ff <= a2_in;
         sum_ff <= sum_in;
         n0_ff <= a0_ff;
         n2_ff <= a2_ff;
         rem2_ff <= rem2_in;
         quo2_ff <= quo2_in;
         den2_ff <= den2_in;
         w0_ff <= w0_in;
         w2_ff <= w2_in;
         c1_ff <= c1_in;
         c2_ff <= c2_in;
         pr_ff <= pr_in;
         acc_ff <= acc_in;
         half_ff <= half_in;
      end
   end

`ifndef ASSERT_OFF
   a_stall_freezes: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> $stable(vld_ff))
      else $error("Pipeline valid bits moved while the output item was stalled.");

   a_min_ratio_one: assert property (@(posedge clock) disable iff (reset)
      vld_ff[STG_SQ-1] |-> (r1quo_ff[DIV_STEPS-1][0] == ONE_Q24
                            || r1quo_ff[DIV_STEPS-1][1] == ONE_Q24
                            || r1quo_ff[DIV_STEPS-1][2] == ONE_Q24))
      else $error("No smoothness ratio equals one for the smallest indicator.");

   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      vld_ff[STG_SQ-1] |-> (r1rem_ff[DIV_STEPS-1][1] < den1_ff[DIV_STEPS-1][1]))
      else $error("Ratio divider remainder is not below its divisor.");

   a_sum_at_least_one: assert property (@(posedge clock) disable iff (reset)
      vld_ff[STG_SUM] |-> (sum_ff >= {2'b00, ONE_Q24}))
      else $error("Weight sum fell below one.");

   a_weights_bounded: assert property (@(posedge clock) disable iff (reset)
      vld_ff[STG_WGT] |-> ({1'b0, w0_ff} + {1'b0, w2_ff} <= {1'b0, ONE_Q24}))
      else $error("Outer normalized weights exceed one.");
`endif

endmodule
